@@ sv/slc_pkg.sv @@
// ---------------------------------------------------------------------------
// slc_pkg - shared types and constants
// Item layouts, configuration register codes and fixed widths used by the
// tag store front end, request queue and back end.
// ---------------------------------------------------------------------------
package slc_pkg;

  localparam int ADDR_W      = 64;
  localparam int CNT_W       = 32;
  localparam int SB_W        = 3;
  localparam int BB_W        = 6;
  localparam int WIU_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  // set index before folding into the store: at most 7 bits
  localparam int IDX_W       = 7;
  localparam int SHIFT_W     = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_BLOCK_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic             first_hit;
    logic             evicted;
    logic [1:0]       hits_added;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } out_item_t;

endpackage

@@ sv/slc_front.sv @@
// ---------------------------------------------------------------------------
// slc_front - request intake and classification
// Holds the configuration registers, accepts accesses and splits each
// address into a folded set index and a tag for the request queue.
// ---------------------------------------------------------------------------
module slc_front
  import slc_pkg::*;
#(
  parameter int MAX_SETS = 64,
  parameter int SET_W    = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output logic                  req_modify,
  output logic [SET_W-1:0]      req_set,
  output logic [ADDR_W-1:0]     req_tag,
  output logic [WIU_W-1:0]      ways_in_use
);

  localparam int FOLD_N = 2 ** IDX_W;

  logic [SB_W-1:0]   set_bits_r;
  logic [BB_W-1:0]   block_bits_r;
  logic [WIU_W-1:0]  ways_r;
  logic [SHIFT_W-1:0] shift_sum;
  logic [ADDR_W-1:0] blk_addr;
  logic [IDX_W-1:0]  idx_mask;
  logic [IDX_W-1:0]  raw_idx;
  logic [SET_W-1:0]  fold_tbl [FOLD_N];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SB_W'(4);
      block_bits_r <= BB_W'(4);
      ways_r       <= WIU_W'(4);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SET_BITS:    set_bits_r   <= cfg_data[SB_W-1:0];
        CFG_BLOCK_BITS:  block_bits_r <= cfg_data[BB_W-1:0];
        CFG_WAYS_IN_USE: ways_r       <= cfg_data[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  // fold the raw index into the store
  for (genvar g = 0; g < FOLD_N; g++) begin : g_fold
    assign fold_tbl[g] = SET_W'(g % MAX_SETS);
  end

  assign shift_sum = {{(SHIFT_W-SB_W){1'b0}}, set_bits_r}
                   + {{(SHIFT_W-BB_W){1'b0}}, block_bits_r};
  assign blk_addr  = in_data.address >> block_bits_r;
  assign idx_mask  = IDX_W'((8'd1 << set_bits_r) - 8'd1);
  assign raw_idx   = blk_addr[IDX_W-1:0] & idx_mask;

  assign req_modify  = in_data.req_type;
  assign req_set     = fold_tbl[raw_idx];
  assign req_tag     = (shift_sum >= SHIFT_W'(ADDR_W)) ? '0 : (in_data.address >> shift_sum);
  assign ways_in_use = ways_r;

  assign busy   = q_full;
  assign q_push = start && !q_full;

endmodule

@@ sv/slc_queue.sv @@
// ---------------------------------------------------------------------------
// slc_queue - request queue
// Short FIFO between the intake and the tag store so each side stalls on
// its own.
// ---------------------------------------------------------------------------
module slc_queue
  import slc_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/slc_back.sv @@
// ---------------------------------------------------------------------------
// slc_back - tag store and LRU engine
// Reads one set row, looks up the tag, fills or evicts, refreshes stamps
// and keeps the saturating hit, miss and eviction totals.
// ---------------------------------------------------------------------------
module slc_back
  import slc_pkg::*;
#(
  parameter int MAX_SETS = 64,
  parameter int WAYS     = 4,
  parameter int SET_W    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic              q_modify,
  input  logic [SET_W-1:0]  q_set,
  input  logic [ADDR_W-1:0] q_tag,
  input  logic [WIU_W-1:0]  ways_in_use,
  output logic              out_strobe,
  output out_item_t         out_data
);

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_SCAN} state_t;

  logic [WAYS-1:0][ADDR_W-1:0] tag_mem   [MAX_SETS];
  logic [WAYS-1:0][ADDR_W-1:0] stamp_mem [MAX_SETS];
  logic [WAYS-1:0][ADDR_W-1:0] tag_row_r;
  logic [WAYS-1:0][ADDR_W-1:0] stamp_row_r;
  logic [WAYS-1:0]             valid_r   [MAX_SETS];

  state_t            state_r;
  logic [SET_W-1:0]  cur_set_r;
  logic [ADDR_W-1:0] cur_tag_r;
  logic              cur_mod_r;
  logic [ADDR_W-1:0] clock_r;
  logic [CNT_W-1:0]  hits_r;
  logic [CNT_W-1:0]  miss_r;
  logic [CNT_W-1:0]  evict_r;
  logic [WCNT_W-1:0] scan_r;
  logic [WAY_W-1:0]  best_r;
  logic [ADDR_W-1:0] best_stamp_r;
  logic              out_strobe_r;
  out_item_t         out_data_r;

  logic [WCNT_W-1:0] nw;
  logic [WAYS-1:0]   valid_row;
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   inv_vec;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [ADDR_W-1:0] scan_stamp;
  logic              done;
  logic              fin_hit;
  logic              fin_evict;
  logic [WAY_W-1:0]  fin_way;
  logic [ADDR_W-1:0] new_stamp;
  logic [1:0]        added;
  logic [CNT_W:0]    hit_sum;
  logic [CNT_W-1:0]  hits_nxt;
  logic [CNT_W-1:0]  miss_nxt;
  logic [CNT_W-1:0]  evict_nxt;

  always_comb begin
    if (ways_in_use == '0) begin
      nw = WCNT_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      nw = WCNT_W'(WAYS);
    end else begin
      nw = WCNT_W'(ways_in_use);
    end
  end

  assign valid_row  = valid_r[cur_set_r];
  assign scan_stamp = stamp_row_r[scan_r[WAY_W-1:0]];

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_row[w] && (w < int'(nw)) && (tag_row_r[w] == cur_tag_r);
      inv_vec[w] = !valid_row[w] && (w < int'(nw));
    end
    // lowest-numbered way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
    end
  end

  always_comb begin
    done      = 1'b0;
    fin_hit   = 1'b0;
    fin_evict = 1'b0;
    fin_way   = best_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_LOOK: begin
        if (|hit_vec) begin
          done    = 1'b1;
          fin_hit = 1'b1;
          fin_way = hit_way;
        end else if (|inv_vec) begin
          done    = 1'b1;
          fin_way = inv_way;
        end
      end
      ST_SCAN: begin
        if (scan_r == nw) begin
          done      = 1'b1;
          fin_evict = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // a modify adds a second access that hits the same line
  assign new_stamp = clock_r + 64'd1 + {{(ADDR_W-1){1'b0}}, cur_mod_r};
  assign added     = {1'b0, fin_hit} + {1'b0, cur_mod_r};
  assign hit_sum   = {1'b0, hits_r} + (CNT_W+1)'(added);
  assign hits_nxt  = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
  assign miss_nxt  = (fin_hit || (&miss_r)) ? miss_r : miss_r + 1'b1;
  assign evict_nxt = (!fin_evict || (&evict_r)) ? evict_r : evict_r + 1'b1;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag_row_r   <= tag_mem[q_set];
      stamp_row_r <= stamp_mem[q_set];
    end
    if (done) begin
      tag_mem[cur_set_r][fin_way]   <= cur_tag_r;
      stamp_mem[cur_set_r][fin_way] <= new_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clock_r      <= '0;
      hits_r       <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      out_strobe_r <= 1'b0;
      for (int s = 0; s < MAX_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      out_strobe_r <= done;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_set_r <= q_set;
            cur_tag_r <= q_tag;
            cur_mod_r <= q_modify;
            state_r   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (!done) begin
            best_r       <= '0;
            best_stamp_r <= stamp_row_r[0];
            scan_r       <= WCNT_W'(1);
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!done) begin
            if (scan_stamp < best_stamp_r) begin
              best_r       <= scan_r[WAY_W-1:0];
              best_stamp_r <= scan_stamp;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (done) begin
        valid_r[cur_set_r][fin_way] <= 1'b1;
        clock_r                     <= new_stamp;
        hits_r                      <= hits_nxt;
        miss_r                      <= miss_nxt;
        evict_r                     <= evict_nxt;
        out_data_r.first_hit        <= fin_hit;
        out_data_r.evicted          <= fin_evict;
        out_data_r.hits_added       <= added;
        out_data_r.total_hits       <= hits_nxt;
        out_data_r.total_misses     <= miss_nxt;
        out_data_r.total_evictions  <= evict_nxt;
        state_r                     <= ST_IDLE;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

@@ sv/set_assoc_lru_cache_sim.sv @@
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_sim - set-associative LRU tag store with counters
// Counts hits, misses and evictions of a stream of memory accesses.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the access is taken at an edge where
//   start is high and busy is low. busy rises only when the two-entry request
//   queue is full.
//   Result: one word per access on out_data, marked by out_strobe for exactly
//   one cycle; the receiver must take it then.
//   Configuration: write set_bits, block_bits and ways_in_use through the
//   cfg_ channel (cfg_ready is always high) while no access is in flight.
//   Flow: a hit or a fill into a free way passes through the request queue, a
//   set-row read and a compare with write-back; an evicting miss adds the
//   oldest-stamp scan over N ways, N being ways_in_use held to 1..WAYS, which
//   compares one way per cycle. The back end takes the next access only after
//   the last one is written back; the queue holds up to two accesses meanwhile.
//   Reset: valid bits, counters and the access clock clear at once, the
//   configuration returns to 4/4/4; no clearing pass is needed.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim
  import slc_pkg::*;
#(
  parameter int MAX_SETS = 64,
  parameter int WAYS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int Q_W   = 1 + SET_W + ADDR_W;

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic              req_modify;
  logic [SET_W-1:0]  req_set;
  logic [ADDR_W-1:0] req_tag;
  logic [WIU_W-1:0]  ways_in_use;
  logic [Q_W-1:0]    q_rdata;

  slc_front #(
    .MAX_SETS (MAX_SETS),
    .SET_W    (SET_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .req_modify  (req_modify),
    .req_set     (req_set),
    .req_tag     (req_tag),
    .ways_in_use (ways_in_use)
  );

  slc_queue #(
    .W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     ({req_modify, req_set, req_tag}),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  slc_back #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS),
    .SET_W    (SET_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_modify    (q_rdata[Q_W-1]),
    .q_set       (q_rdata[ADDR_W +: SET_W]),
    .q_tag       (q_rdata[ADDR_W-1:0]),
    .ways_in_use (ways_in_use),
    .out_strobe  (out_strobe),
    .out_data    (out_data)
  );

  // every access passes through the idle and lookup states, so result strobes are never adjacent
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes in back-to-back cycles");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.evicted) |-> !out_data.first_hit)
    else $error("eviction reported on a hit");

  a_miss_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.first_hit) |-> (out_data.hits_added != 2'd2))
    else $error("two hits added on a first-access miss");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("strobe or busy set right after reset");

endmodule
